@@ hdl/fdv_pkg.sv @@
// Shared types, constants and divider step function for the filtered
// difference velocity block. No dependencies.
package fdv_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_GAIN_XY_DIFF = 3'd0;
	localparam logic [2:0] REG_GAIN_XY_PREV = 3'd1;
	localparam logic [2:0] REG_GAIN_Z_DIFF  = 3'd2;
	localparam logic [2:0] REG_GAIN_Z_PREV  = 3'd3;
	localparam logic [2:0] REG_HOLD_DT      = 3'd4;

	// Result status codes
	localparam logic [1:0] STAT_UPDATED   = 2'd0;
	localparam logic [1:0] STAT_FIRST     = 2'd1;
	localparam logic [1:0] STAT_HELD      = 2'd2;
	localparam logic [1:0] STAT_SATURATED = 2'd3;

	// Reset values of the registers
	localparam logic [16:0] GAIN_DIFF_RST = 17'd58982;
	localparam logic [16:0] GAIN_PREV_RST = 17'd6554;
	localparam logic [19:0] HOLD_DT_RST   = 20'd100;

	// Arithmetic constants
	localparam logic [19:0] US_PER_S  = 20'd1000000;
	localparam int          DIVW      = 70;   // dividend width, even
	localparam int          DIV_STEPS = DIVW / 2;
	// (2^40 + 1) * 1e6: scaled quotient at or above this means |p/dt| > 2^40
	localparam logic [DIVW-1:0] QUOT_LIM = 70'd1099511627777000000;

	localparam logic signed [31:0] VEL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VEL_MIN = 32'sh8000_0000;

	// Lane sequencing strobes
	typedef struct packed {
		logic load;
		logic mul;
		logic absv;
		logic pp;
		logic sum;
		logic step;
		logic fin1;
		logic fin2;
	} fdv_ctrl_t;

	// What one lane reports
	typedef struct packed {
		logic signed [31:0] vel;
		logic               sat;
	} fdv_lane_res_t;

	// One restoring division step
	typedef struct packed {
		logic [31:0] rem;
		logic        qbit;
	} fdv_dstep_t;

	function automatic fdv_dstep_t div_step(input logic [31:0] rem, input logic nbit,
			input logic [30:0] dvs);
		logic [31:0] t;
		logic [32:0] diff;
		fdv_dstep_t  r;
		t    = {rem[30:0], nbit};
		diff = {1'b0, t} - {2'b00, dvs};
		if (!diff[32]) begin
			r.rem  = diff[31:0];
			r.qbit = 1'b1;
		end else begin
			r.rem  = t;
			r.qbit = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ hdl/fdv_ifs.sv @@
// Valid/ready channel interfaces for samples and velocity results.
// No dependencies.
interface fdv_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] delta_time;

	modport source (output valid, pos_x, pos_y, pos_z, delta_time, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, delta_time, output ready);
endinterface

interface fdv_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic        [1:0]  status;

	modport source (output valid, vel_x, vel_y, vel_z, status, input ready);
	modport sink   (input valid, vel_x, vel_y, vel_z, status, output ready);
endinterface

@@ hdl/filtered_difference_velocity_top.sv @@
// Filtered difference velocity, top level: config registers, sequencer,
// three axis lanes and the merge stage. Depends on fdv_pkg, fdv_ifs, fdv_lane.
// One word at a time: a new sample is accepted only in the idle state, after
// the last result has been loaded into the output register. A computed word
// runs through the radix-4 divider in each lane; a first or held word does not.
// Reset (arst_n low) restores register defaults, zero velocity, first flag.
module filtered_difference_velocity_top (
	input  logic                clk,
	input  logic                arst_n,
	fdv_sample_if.sink          sample,
	fdv_result_if.source        result,
	input  logic                cfg_wr_en,
	input  logic        [2:0]   cfg_index,
	input  logic        [19:0]  cfg_wr_data
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_MUL   = 10'b00_0000_0010,
		S_ABS   = 10'b00_0000_0100,
		S_PP    = 10'b00_0000_1000,
		S_SUM   = 10'b00_0001_0000,
		S_DIV   = 10'b00_0010_0000,
		S_FIN1  = 10'b00_0100_0000,
		S_FIN2  = 10'b00_1000_0000,
		S_MERGE = 10'b01_0000_0000,
		S_OUT   = 10'b10_0000_0000
	} fdv_state_t;

	fdv_state_t state_q;

	logic [16:0] gain_xy_diff_q, gain_xy_prev_q, gain_z_diff_q, gain_z_prev_q;
	logic [19:0] hold_dt_q;

	logic signed [31:0] last_pos_x_q, last_pos_y_q, last_pos_z_q;
	logic signed [31:0] last_vel_x_q, last_vel_y_q, last_vel_z_q;
	logic               first_q;
	logic        [30:0] dt_q;
	logic        [5:0]  step_cnt_q;

	logic signed [31:0] res_x_q, res_y_q, res_z_q;
	logic        [1:0]  res_stat_q;

	logic               out_valid_q;
	logic signed [31:0] out_x_q, out_y_q, out_z_q;
	logic        [1:0]  out_stat_q;

	logic               accept;
	logic               held;
	logic               out_load;
	fdv_pkg::fdv_ctrl_t ctrl;
	fdv_pkg::fdv_lane_res_t lane_x, lane_y, lane_z;

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign held         = $signed(sample.delta_time) <= $signed({12'd0, hold_dt_q});
	assign out_load     = (state_q == S_OUT) && (!out_valid_q || result.ready);

	// lane strobes
	always_comb begin
		ctrl.load = accept;
		ctrl.mul  = (state_q == S_MUL);
		ctrl.absv = (state_q == S_ABS);
		ctrl.pp   = (state_q == S_PP);
		ctrl.sum  = (state_q == S_SUM);
		ctrl.step = (state_q == S_DIV);
		ctrl.fin1 = (state_q == S_FIN1);
		ctrl.fin2 = (state_q == S_FIN2);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_xy_diff_q <= fdv_pkg::GAIN_DIFF_RST;
			gain_xy_prev_q <= fdv_pkg::GAIN_PREV_RST;
			gain_z_diff_q  <= fdv_pkg::GAIN_DIFF_RST;
			gain_z_prev_q  <= fdv_pkg::GAIN_PREV_RST;
			hold_dt_q      <= fdv_pkg::HOLD_DT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fdv_pkg::REG_GAIN_XY_DIFF: gain_xy_diff_q <= cfg_wr_data[16:0];
				fdv_pkg::REG_GAIN_XY_PREV: gain_xy_prev_q <= cfg_wr_data[16:0];
				fdv_pkg::REG_GAIN_Z_DIFF:  gain_z_diff_q  <= cfg_wr_data[16:0];
				fdv_pkg::REG_GAIN_Z_PREV:  gain_z_prev_q  <= cfg_wr_data[16:0];
				fdv_pkg::REG_HOLD_DT:      hold_dt_q      <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	// stored position and divisor (payload, no reset)
	always_ff @(posedge clk) begin
		if (accept) begin
			last_pos_x_q <= sample.pos_x;
			last_pos_y_q <= sample.pos_y;
			last_pos_z_q <= sample.pos_z;
			dt_q         <= sample.delta_time[30:0];
		end
	end

	// sequencer, velocity state and merge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_q      <= 1'b1;
			last_vel_x_q <= '0;
			last_vel_y_q <= '0;
			last_vel_z_q <= '0;
			step_cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (first_q) begin
							first_q      <= 1'b0;
							last_vel_x_q <= '0;
							last_vel_y_q <= '0;
							last_vel_z_q <= '0;
							state_q      <= S_OUT;
						end else if (held) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL:  state_q <= S_ABS;
				S_ABS:  state_q <= S_PP;
				S_PP:   state_q <= S_SUM;
				S_SUM: begin
					step_cnt_q <= '0;
					state_q    <= S_DIV;
				end
				S_DIV: begin
					if (step_cnt_q == 6'(fdv_pkg::DIV_STEPS - 1)) begin
						state_q <= S_FIN1;
					end else begin
						step_cnt_q <= step_cnt_q + 6'd1;
					end
				end
				S_FIN1: state_q <= S_FIN2;
				S_FIN2: state_q <= S_MERGE;
				S_MERGE: begin
					last_vel_x_q <= lane_x.vel;
					last_vel_y_q <= lane_y.vel;
					last_vel_z_q <= lane_z.vel;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pending result word
	always_ff @(posedge clk) begin
		if (accept) begin
			if (first_q) begin
				res_x_q    <= '0;
				res_y_q    <= '0;
				res_z_q    <= '0;
				res_stat_q <= fdv_pkg::STAT_FIRST;
			end else begin
				res_x_q    <= last_vel_x_q;
				res_y_q    <= last_vel_y_q;
				res_z_q    <= last_vel_z_q;
				res_stat_q <= fdv_pkg::STAT_HELD;
			end
		end else if (state_q == S_MERGE) begin
			res_x_q    <= lane_x.vel;
			res_y_q    <= lane_y.vel;
			res_z_q    <= lane_z.vel;
			res_stat_q <= (lane_x.sat || lane_y.sat || lane_z.sat) ?
				fdv_pkg::STAT_SATURATED : fdv_pkg::STAT_UPDATED;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q    <= res_x_q;
			out_y_q    <= res_y_q;
			out_z_q    <= res_z_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.vel_x  = out_x_q;
	assign result.vel_y  = out_y_q;
	assign result.vel_z  = out_z_q;
	assign result.status = out_stat_q;

	// axis lanes
	fdv_lane u_lane_x (
		.clk       (clk),
		.ctrl      (ctrl),
		.pos       (sample.pos_x),
		.prev_pos  (last_pos_x_q),
		.prev_vel  (last_vel_x_q),
		.gain_diff (gain_xy_diff_q),
		.gain_prev (gain_xy_prev_q),
		.divisor   (dt_q),
		.res       (lane_x)
	);

	fdv_lane u_lane_y (
		.clk       (clk),
		.ctrl      (ctrl),
		.pos       (sample.pos_y),
		.prev_pos  (last_pos_y_q),
		.prev_vel  (last_vel_y_q),
		.gain_diff (gain_xy_diff_q),
		.gain_prev (gain_xy_prev_q),
		.divisor   (dt_q),
		.res       (lane_y)
	);

	fdv_lane u_lane_z (
		.clk       (clk),
		.ctrl      (ctrl),
		.pos       (sample.pos_z),
		.prev_pos  (last_pos_z_q),
		.prev_vel  (last_vel_z_q),
		.gain_diff (gain_z_diff_q),
		.gain_prev (gain_z_prev_q),
		.divisor   (dt_q),
		.res       (lane_z)
	);

endmodule

@@ hdl/fdv_lane.sv @@
// One axis lane: difference, gain multiplies, scaled radix-4 division,
// filter sum and saturation. Depends on fdv_pkg.
module fdv_lane (
	input  logic                   clk,
	input  fdv_pkg::fdv_ctrl_t     ctrl,
	input  logic signed [31:0]     pos,
	input  logic signed [31:0]     prev_pos,
	input  logic signed [31:0]     prev_vel,
	input  logic        [16:0]     gain_diff,
	input  logic        [16:0]     gain_prev,
	input  logic        [30:0]     divisor,
	output fdv_pkg::fdv_lane_res_t res
);

	logic signed [32:0] d_q;
	logic signed [49:0] p_q;
	logic signed [49:0] b_q;
	logic               neg_q;
	logic        [48:0] mag_q;
	logic        [43:0] pp_hi_q;
	logic        [44:0] pp_lo_q;
	logic        [31:0] rem_q;
	logic [fdv_pkg::DIVW-1:0] quo_q;
	logic               big_q;
	logic signed [62:0] total_q;
	fdv_pkg::fdv_lane_res_t res_q;

	logic signed [49:0] d_ext, ga_ext, pv_ext, gb_ext;
	logic        [43:0] hi_prod;
	logic        [44:0] lo_prod;
	fdv_pkg::fdv_dstep_t st0, st1;
	logic signed [62:0] a_mag, a_sgn, b_ext;
	logic signed [46:0] v_shift;
	logic               ovf;

	// operand extension to product width
	assign d_ext  = {{17{d_q[32]}}, d_q};
	assign ga_ext = {33'd0, gain_diff};
	assign pv_ext = {{18{prev_vel[31]}}, prev_vel};
	assign gb_ext = {33'd0, gain_prev};

	// partial products of |p| * 1e6
	assign hi_prod = {20'd0, mag_q[48:25]} * {24'd0, fdv_pkg::US_PER_S};
	assign lo_prod = {20'd0, mag_q[24:0]} * {25'd0, fdv_pkg::US_PER_S};

	// two division steps per cycle
	assign st0 = fdv_pkg::div_step(rem_q, quo_q[fdv_pkg::DIVW-1], divisor);
	assign st1 = fdv_pkg::div_step(st0.rem, quo_q[fdv_pkg::DIVW-2], divisor);

	// signed filter terms
	assign a_mag = {3'd0, quo_q[59:0]};
	assign a_sgn = neg_q ? -a_mag : a_mag;
	assign b_ext = {{13{b_q[49]}}, b_q};

	// floor divide by gain one, then range check
	assign v_shift = 47'(total_q >>> 16);
	assign ovf     = (v_shift[46:31] != {16{v_shift[31]}});

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			d_q <= $signed({pos[31], pos}) - $signed({prev_pos[31], prev_pos});
		end
		if (ctrl.mul) begin
			p_q <= d_ext * ga_ext;
			b_q <= pv_ext * gb_ext;
		end
		if (ctrl.absv) begin
			neg_q <= p_q[49];
			mag_q <= p_q[49] ? 49'(-p_q) : 49'(p_q);
		end
		if (ctrl.pp) begin
			pp_hi_q <= hi_prod;
			pp_lo_q <= lo_prod;
		end
		if (ctrl.sum) begin
			quo_q <= {1'b0, pp_hi_q, 25'd0} + {25'd0, pp_lo_q};
			rem_q <= '0;
		end else if (ctrl.step) begin
			quo_q <= {quo_q[fdv_pkg::DIVW-3:0], st0.qbit, st1.qbit};
			rem_q <= st1.rem;
		end
		if (ctrl.fin1) begin
			big_q   <= (quo_q >= fdv_pkg::QUOT_LIM);
			total_q <= a_sgn + b_ext;
		end
		if (ctrl.fin2) begin
			if (big_q) begin
				res_q.vel <= neg_q ? fdv_pkg::VEL_MIN : fdv_pkg::VEL_MAX;
				res_q.sat <= 1'b1;
			end else if (ovf) begin
				res_q.vel <= v_shift[46] ? fdv_pkg::VEL_MIN : fdv_pkg::VEL_MAX;
				res_q.sat <= 1'b1;
			end else begin
				res_q.vel <= v_shift[31:0];
				res_q.sat <= 1'b0;
			end
		end
	end

	assign res = res_q;

endmodule
